>>> sv/mesh_route_direction_compute_unit_assert.svh
// Assertion macros shared by the route computation unit.
`ifndef MESH_ROUTE_DIRECTION_COMPUTE_UNIT_ASSERT_SVH
`define MESH_ROUTE_DIRECTION_COMPUTE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define MRDC_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define MRDC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/mrdc_pkg.sv
// Types, constants and route selection functions of the route computation unit.
`timescale 1ns / 1ps
package mrdc_pkg;

	// Width of a cell id and number of divider cells (one quotient bit each).
	localparam int ID_W       = 16;
	localparam int DIV_STAGES = ID_W;
	localparam int COORD_W    = 8;
	localparam int COLS_W     = 9;
	localparam int MAX_SIDE   = 256;

	// Output port codes.
	localparam logic [1:0] DIR_LEFT  = 2'd0;
	localparam logic [1:0] DIR_UP    = 2'd1;
	localparam logic [1:0] DIR_RIGHT = 2'd2;
	localparam logic [1:0] DIR_DOWN  = 2'd3;

	// Port counts.
	localparam logic [1:0] CNT_NONE = 2'd0;
	localparam logic [1:0] CNT_ONE  = 2'd1;
	localparam logic [1:0] CNT_TWO  = 2'd2;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_GRID_COLUMNS = 2'd0,
		REG_CELL_COL     = 2'd1,
		REG_CELL_ROW     = 2'd2,
		REG_ROUTE_MODE   = 2'd3
	} cfg_reg_t;

	// Routing algorithms.
	typedef enum logic [2:0] {
		MODE_XY         = 3'd0,
		MODE_YX         = 3'd1,
		MODE_WEST       = 3'd2,
		MODE_WEST_ADAPT = 3'd3,
		MODE_POSITIVE   = 3'd4,
		MODE_MIXED      = 3'd5
	} route_mode_t;

	// Request transaction.
	typedef struct packed {
		logic [ID_W-1:0] dst_id;
		logic [ID_W-1:0] src_id;
	} req_t;

	// Result transaction.
	typedef struct packed {
		logic [1:0] first_dir;
		logic [1:0] second_dir;
		logic [1:0] dir_count;
	} rsp_t;

	// Cell position and algorithm as seen by the route cell.
	typedef struct packed {
		logic [COORD_W-1:0] cell_col;
		logic [COORD_W-1:0] cell_row;
		route_mode_t        route_mode;
	} route_cfg_t;

	// Partial division state handed from one divider cell to the next.
	typedef struct packed {
		logic [ID_W-1:0]    dst_num;
		logic [ID_W-1:0]    src_num;
		logic [ID_W-1:0]    quot;
		logic [COORD_W-1:0] dst_rem;
		logic [COORD_W-1:0] src_rem;
	} div_data_t;

	// Coordinate comparison flags of one request.
	typedef struct packed {
		logic west;
		logic east;
		logic north;
		logic south;
	} cmp_t;

	function automatic rsp_t mk_one(logic [1:0] d);
		rsp_t r;
		r.first_dir  = d;
		r.second_dir = DIR_LEFT;
		r.dir_count  = CNT_ONE;
		return r;
	endfunction

	function automatic rsp_t mk_two(logic [1:0] d0, logic [1:0] d1);
		rsp_t r;
		r.first_dir  = d0;
		r.second_dir = d1;
		r.dir_count  = CNT_TWO;
		return r;
	endfunction

	function automatic rsp_t mk_none();
		rsp_t r;
		r.first_dir  = DIR_LEFT;
		r.second_dir = DIR_LEFT;
		r.dir_count  = CNT_NONE;
		return r;
	endfunction

	// Dimension order, columns first.
	function automatic rsp_t pick_xy(cmp_t c);
		rsp_t r;
		priority if (c.west)  r = mk_one(DIR_LEFT);
		else if (c.east)      r = mk_one(DIR_RIGHT);
		else if (c.north)     r = mk_one(DIR_UP);
		else if (c.south)     r = mk_one(DIR_DOWN);
		else                  r = mk_none();
		return r;
	endfunction

	// Dimension order, rows first.
	function automatic rsp_t pick_yx(cmp_t c);
		rsp_t r;
		priority if (c.north) r = mk_one(DIR_UP);
		else if (c.south)     r = mk_one(DIR_DOWN);
		else if (c.east)      r = mk_one(DIR_RIGHT);
		else if (c.west)      r = mk_one(DIR_LEFT);
		else                  r = mk_none();
		return r;
	endfunction

	// West-first turn model, optionally offering the east port as a second choice.
	function automatic rsp_t pick_west(cmp_t c, logic adaptive);
		rsp_t r;
		priority if (c.west)         r = mk_one(DIR_LEFT);
		else if (c.east && c.north)
			r = adaptive ? mk_two(DIR_UP, DIR_RIGHT) : mk_one(DIR_UP);
		else if (c.east && c.south)
			r = adaptive ? mk_two(DIR_DOWN, DIR_RIGHT) : mk_one(DIR_DOWN);
		else if (c.east)             r = mk_one(DIR_RIGHT);
		else if (c.south)            r = mk_one(DIR_DOWN);
		else if (c.north)            r = mk_one(DIR_UP);
		else                         r = mk_none();
		return r;
	endfunction

	// Fully adaptive minimal routing over both productive ports.
	function automatic rsp_t pick_positive(cmp_t c);
		rsp_t r;
		priority if (c.west && c.south) r = mk_two(DIR_LEFT, DIR_DOWN);
		else if (c.west && c.north)     r = mk_two(DIR_LEFT, DIR_UP);
		else if (c.east && c.north)     r = mk_two(DIR_UP, DIR_RIGHT);
		else if (c.east && c.south)     r = mk_two(DIR_DOWN, DIR_RIGHT);
		else if (c.west)                r = mk_one(DIR_LEFT);
		else if (c.east)                r = mk_one(DIR_RIGHT);
		else if (c.south)               r = mk_one(DIR_DOWN);
		else if (c.north)               r = mk_one(DIR_UP);
		else                            r = mk_none();
		return r;
	endfunction

	// Select the algorithm; unused mode codes fall back to XY.
	function automatic rsp_t route_pick(route_mode_t mode, cmp_t c, logic src_odd);
		rsp_t r;
		unique case (mode)
			MODE_XY:         r = pick_xy(c);
			MODE_YX:         r = pick_yx(c);
			MODE_WEST:       r = pick_west(c, 1'b0);
			MODE_WEST_ADAPT: r = pick_west(c, 1'b1);
			MODE_POSITIVE:   r = pick_positive(c);
			MODE_MIXED:      r = src_odd ? pick_yx(c) : pick_xy(c);
			default:         r = pick_xy(c);
		endcase
		return r;
	endfunction

endpackage

>>> sv/mrdc_div_cell.sv
// One restoring-division cell: produces one quotient bit for the destination id and a remainder step for both ids.
`timescale 1ns / 1ps
module mrdc_div_cell
	import mrdc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [COLS_W-1:0] divisor,
	input  logic              up_valid,
	input  div_data_t         up_data,
	output logic              up_ready,
	output logic              dn_valid,
	output div_data_t         dn_data,
	input  logic              dn_ready
);

	logic              valid_q;
	div_data_t         data_q;
	div_data_t         step;
	logic [COLS_W-1:0] trial_dst;
	logic [COLS_W-1:0] trial_src;
	logic              ge_dst;
	logic              ge_src;
	logic [COLS_W-1:0] diff_dst;
	logic [COLS_W-1:0] diff_src;

	// Shift in the next id bit and subtract the divisor where it fits.
	always_comb begin
		trial_dst = {up_data.dst_rem, up_data.dst_num[ID_W-1]};
		trial_src = {up_data.src_rem, up_data.src_num[ID_W-1]};
		ge_dst    = trial_dst >= divisor;
		ge_src    = trial_src >= divisor;
		diff_dst  = trial_dst - divisor;
		diff_src  = trial_src - divisor;
		step.dst_num = {up_data.dst_num[ID_W-2:0], 1'b0};
		step.src_num = {up_data.src_num[ID_W-2:0], 1'b0};
		step.quot    = {up_data.quot[ID_W-2:0], ge_dst};
		step.dst_rem = ge_dst ? diff_dst[COORD_W-1:0] : trial_dst[COORD_W-1:0];
		step.src_rem = ge_src ? diff_src[COORD_W-1:0] : trial_src[COORD_W-1:0];
	end

	// The cell takes a new transaction when it is empty or its contents move on.
	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= step;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule

>>> sv/mrdc_route_cell.sv
// Last cell of the chain: compares coordinates, picks ports and holds the result.
`timescale 1ns / 1ps
module mrdc_route_cell
	import mrdc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  route_cfg_t cfg,
	input  logic       up_valid,
	input  div_data_t  up_data,
	output logic       up_ready,
	output logic       rsp_valid,
	output rsp_t       rsp,
	input  logic       rsp_stall
);

	logic valid_q;
	rsp_t rsp_q;
	cmp_t cmp;
	rsp_t pick;

	// Rows are compared at full quotient width so that rows past 255 lie below every cell.
	always_comb begin
		cmp.west  = cfg.cell_col > up_data.dst_rem;
		cmp.east  = cfg.cell_col < up_data.dst_rem;
		cmp.north = {{(ID_W-COORD_W){1'b0}}, cfg.cell_row} > up_data.quot;
		cmp.south = {{(ID_W-COORD_W){1'b0}}, cfg.cell_row} < up_data.quot;
		pick      = route_pick(cfg.route_mode, cmp, up_data.src_rem[0]);
	end

	// The result register frees up when it is empty or the receiver takes its contents.
	assign up_ready = !valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			rsp_q <= pick;
		end
	end

	assign rsp_valid = valid_q;
	assign rsp       = rsp_q;

endmodule

>>> sv/mesh_route_direction_compute_unit.sv
// Top level of the mesh route computation unit: configuration registers and the cell chain.
//
//   Channel | Handshake             | Payload
//   --------+-----------------------+-------------------------------------------
//   req     | req_valid, req_stall  | req (dst_id, src_id)
//   rsp     | rsp_valid, rsp_stall  | rsp (first_dir, second_dir, dir_count)
//   cfg     | cfg_valid, cfg_ready  | cfg_index, cfg_data
//
// A request enters every cycle while req_stall is low; its result appears after the
// sixteen divider cells (one quotient bit each) and the route cell.
// Reset empties every cell and loads the register defaults; no clearing pass.
// A stall on rsp backs up through the chain only as far as full cells reach,
// so req_stall rises only when every cell holds a transaction.
`timescale 1ns / 1ps
`include "mesh_route_direction_compute_unit_assert.svh"
module mesh_route_direction_compute_unit
	import mrdc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  req_t              req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rsp_t              rsp,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [COLS_W-1:0] cfg_data
);

	logic [COLS_W-1:0]  grid_columns_q;
	logic [COORD_W-1:0] cell_col_q;
	logic [COORD_W-1:0] cell_row_q;
	route_mode_t        route_mode_q;
	logic [COLS_W-1:0]  eff_cols;
	route_cfg_t         route_cfg;

	logic              chain_valid [DIV_STAGES+1];
	logic              chain_ready [DIV_STAGES+1];
	div_data_t         chain_data  [DIV_STAGES+1];

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_columns_q <= COLS_W'(16);
			cell_col_q     <= '0;
			cell_row_q     <= '0;
			route_mode_q   <= MODE_XY;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_GRID_COLUMNS: grid_columns_q <= cfg_data;
				REG_CELL_COL:     cell_col_q     <= cfg_data[COORD_W-1:0];
				REG_CELL_ROW:     cell_row_q     <= cfg_data[COORD_W-1:0];
				REG_ROUTE_MODE:   route_mode_q   <= route_mode_t'(cfg_data[2:0]);
			endcase
		end
	end

	// A column count of zero acts as one, and counts past the largest side saturate.
	always_comb begin
		priority if (grid_columns_q == '0) begin
			eff_cols = COLS_W'(1);
		end else if (grid_columns_q > COLS_W'(MAX_SIDE)) begin
			eff_cols = COLS_W'(MAX_SIDE);
		end else begin
			eff_cols = grid_columns_q;
		end
	end

	assign route_cfg.cell_col   = cell_col_q;
	assign route_cfg.cell_row   = cell_row_q;
	assign route_cfg.route_mode = route_mode_q;

	// Head of the chain: the ids enter with empty remainders and quotient.
	assign chain_valid[0]        = req_valid;
	assign chain_data[0].dst_num = req.dst_id;
	assign chain_data[0].src_num = req.src_id;
	assign chain_data[0].quot    = '0;
	assign chain_data[0].dst_rem = '0;
	assign chain_data[0].src_rem = '0;
	assign req_stall             = !chain_ready[0];

	// Divider cells, most significant quotient bit first.
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		mrdc_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.divisor  (eff_cols),
			.up_valid (chain_valid[k]),
			.up_data  (chain_data[k]),
			.up_ready (chain_ready[k]),
			.dn_valid (chain_valid[k+1]),
			.dn_data  (chain_data[k+1]),
			.dn_ready (chain_ready[k+1])
		);
	end

	// Route selection and result register.
	mrdc_route_cell u_route (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (route_cfg),
		.up_valid  (chain_valid[DIV_STAGES]),
		.up_data   (chain_data[DIV_STAGES]),
		.up_ready  (chain_ready[DIV_STAGES]),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.rsp_stall (rsp_stall)
	);

	// Back-pressure on requests can only come from a held result.
	`MRDC_ASSERT_IMPLIES(a_stall_source, req_stall, rsp_valid && rsp_stall, "request stall without a held result")
	// An arrived transaction names no ports.
	`MRDC_ASSERT_IMPLIES(a_arrived_clean, rsp_valid && rsp.dir_count == CNT_NONE, rsp.first_dir == DIR_LEFT && rsp.second_dir == DIR_LEFT, "arrived result carries a port")
	// Two ports are offered only by the adaptive algorithms.
	`MRDC_ASSERT_IMPLIES(a_two_ports_adaptive, rsp_valid && rsp.dir_count == CNT_TWO, route_mode_q == MODE_WEST_ADAPT || route_mode_q == MODE_POSITIVE, "two ports in a deterministic mode")
	// A taken result with nothing behind it leaves the output empty.
	`MRDC_ASSERT_NEXT(a_drain, rsp_valid && !rsp_stall && !chain_valid[DIV_STAGES], !rsp_valid, "result repeated after it was taken")

endmodule
